// ----- src/poly_voice_allocator_macros.svh -----
// assertion helpers for the voice allocator
`ifndef POLY_VOICE_ALLOCATOR_MACROS_SVH
`define POLY_VOICE_ALLOCATOR_MACROS_SVH

// condition that must hold on every clock out of reset
`define PVA_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// implication checked on every clock out of reset
`define PVA_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/pva_pkg.sv -----
package pva_pkg;

  localparam int VIDX_W  = 4;
  localparam int CMD_MAX = 32;
  localparam int CNT_W   = 6;

  // input kinds
  localparam logic [2:0] KIND_NOTE_ON    = 3'd0;
  localparam logic [2:0] KIND_NOTE_OFF   = 3'd1;
  localparam logic [2:0] KIND_SUSTAIN    = 3'd2;
  localparam logic [2:0] KIND_PORTA_EN   = 3'd3;
  localparam logic [2:0] KIND_PORTA_TIME = 3'd4;
  localparam logic [2:0] KIND_ALL_OFF    = 3'd5;
  localparam logic [2:0] KIND_PANIC      = 3'd6;
  localparam logic [2:0] KIND_TICK       = 3'd7;

  // command actions
  localparam logic [2:0] ACT_LFO_RETRIG = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_OSC_RESET  = 3'd2;
  localparam logic [2:0] ACT_GLIDE_FROM = 3'd3;
  localparam logic [2:0] ACT_TAKE_SIG   = 3'd4;
  localparam logic [2:0] ACT_TAKE_STATE = 3'd5;
  localparam logic [2:0] ACT_KEY_REL    = 3'd6;
  localparam logic [2:0] ACT_FREED      = 3'd7;

  // configuration register indexes
  localparam logic CFG_MONO_MODE = 1'b0;
  localparam logic CFG_OSC_SYNC  = 1'b1;

  localparam logic [6:0] CTRL_ON_MIN = 7'd64;

  typedef enum logic [2:0] {
    OP_PRESS, OP_RELEASE, OP_SUSTAIN, OP_PORTA_EN,
    OP_PORTA_TIME, OP_ALL_OFF, OP_PANIC, OP_TICK
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [6:0]  ctrl_value;
    logic [15:0] released_mask;
  } item_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] voice;
    logic [3:0] src;
    logic [6:0] pitch;
    logic [6:0] velocity;
    logic [3:0] channel;
  } cmd_t;

  typedef struct packed {
    logic             busy;
    logic             pend_valid;
    logic [CNT_W-1:0] emit_cnt;
  } status_t;

endpackage

// ----- src/pva_in_if.sv -----
interface pva_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  channel;
  logic [6:0]  pitch;
  logic [6:0]  velocity;
  logic [6:0]  ctrl_value;
  logic [15:0] released_mask;

  modport source (output valid, kind, channel, pitch, velocity, ctrl_value, released_mask,
                  input ready);
  modport sink (input valid, kind, channel, pitch, velocity, ctrl_value, released_mask,
                output ready);
endinterface

// ----- src/pva_out_if.sv -----
interface pva_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [3:0] voice_index;
  logic [3:0] source_voice;
  logic [6:0] note_pitch;
  logic [6:0] note_velocity;
  logic [3:0] note_channel;
  logic       last;

  modport source (output valid, action, voice_index, source_voice, note_pitch,
                  note_velocity, note_channel, last, input ready);
  modport sink (input valid, action, voice_index, source_voice, note_pitch,
                note_velocity, note_channel, last, output ready);
endinterface

// ----- src/poly_voice_allocator.sv -----
// Polyphonic voice allocator. Requests on in_ch are classified and queued (two deep), then
// a sequencer works them one at a time and sends voice commands on out_ch through an output
// register. The sequencer walks the voices one voice a cycle, held while out_ch stalls:
// a note-on runs a round-robin search for a free voice, walks every voice to steal the
// oldest when all are held, then applies the note and steps the LFO, start, oscillator,
// glide and mono states; a note-off searches for the key, then in mono mode seeks the
// highest held note; sustain release, panic and block tick walk every voice; all-notes-off
// releases each held voice in turn. At most 32 commands go out per request, the last marked.
`include "poly_voice_allocator_macros.svh"

module poly_voice_allocator #(
  parameter int VOICES = 16
) (
  input  logic clk,
  input  logic rst,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch,
  input  logic cfg_we,
  input  logic cfg_addr,
  input  logic cfg_wdata
);
  import pva_pkg::*;

  logic    mono_mode;
  logic    osc_sync_enable;
  logic    q_valid;
  item_t   q_item;
  logic    pop;
  status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      mono_mode       <= 1'b0;
      osc_sync_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MONO_MODE: mono_mode       <= cfg_wdata;
        CFG_OSC_SYNC:  osc_sync_enable <= cfg_wdata;
        default:       mono_mode       <= mono_mode;
      endcase
    end
  end

  pva_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .pop     (pop)
  );

  pva_back #(.VOICES(VOICES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .mono_mode (mono_mode),
    .osc_sync  (osc_sync_enable),
    .out_ch    (out_ch),
    .status    (status)
  );

  `PVA_IMPLY(a_idle_no_pend, !status.busy, !status.pend_valid, "command held while idle")
  `PVA_ALWAYS(a_cmd_cap, status.emit_cnt <= CNT_W'(CMD_MAX), "command count over cap")
  `PVA_IMPLY(a_start_vel, out_ch.valid && (out_ch.action == ACT_START), out_ch.note_velocity != 7'd0, "start with zero velocity")
endmodule

// ----- src/pva_front.sv -----
module pva_front (
  input  logic           clk,
  input  logic           rst,
  pva_in_if.sink         in_ch,
  output logic           q_valid,
  output pva_pkg::item_t q_item,
  input  logic           pop
);
  import pva_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  // classify the request
  always_comb begin
    cls.channel       = in_ch.channel;
    cls.pitch         = in_ch.pitch;
    cls.velocity      = in_ch.velocity;
    cls.ctrl_value    = in_ch.ctrl_value;
    cls.released_mask = in_ch.released_mask;
    case (in_ch.kind)
      KIND_NOTE_ON:    cls.op = (in_ch.velocity == 7'd0) ? OP_RELEASE : OP_PRESS;
      KIND_NOTE_OFF:   cls.op = OP_RELEASE;
      KIND_SUSTAIN:    cls.op = OP_SUSTAIN;
      KIND_PORTA_EN:   cls.op = OP_PORTA_EN;
      KIND_PORTA_TIME: cls.op = OP_PORTA_TIME;
      KIND_ALL_OFF:    cls.op = OP_ALL_OFF;
      KIND_PANIC:      cls.op = OP_PANIC;
      default:         cls.op = OP_TICK;
    endcase
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count != 2'd0);
  assign q_item      = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !(pop && q_valid)) begin
        count <= count + 2'd1;
      end else if (!push && pop && q_valid) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// ----- src/pva_back.sv -----
module pva_back #(
  parameter int VOICES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  pva_pkg::item_t   q_item,
  output logic             pop,
  input  logic             mono_mode,
  input  logic             osc_sync,
  pva_out_if.source        out_ch,
  output pva_pkg::status_t status
);
  import pva_pkg::*;

  localparam int VW = $clog2(VOICES);
  localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_P_FIND, S_P_STEAL, S_P_APPLY, S_P_LFO, S_P_START, S_P_OSC,
    S_P_GLIDE, S_P_MONO, S_R_FIND, S_R_MONO, S_R_XFER, S_R_SUS, S_ANO,
    S_SUS, S_PANIC, S_TICK, S_DONE
  } state_t;

  state_t           state;
  item_t            it;
  logic [VOICES-1:0] held;
  logic [VOICES-1:0] sust;
  logic [VOICES-1:0] live;
  logic [6:0]       vpitch [VOICES];
  logic [31:0]      vage [VOICES];
  logic [31:0]      note_counter;
  logic [VW-1:0]    next_voice;
  logic [VW-1:0]    last_active;
  logic             last_valid;
  logic             sustain_on;
  logic             porta_en;
  logic [6:0]       porta_time;

  logic [VW-1:0]    idx;
  logic [VW-1:0]    vi;
  logic [VW-1:0]    cnt;
  logic [VW-1:0]    n;
  logic [VW-1:0]    best;
  logic [31:0]      best_age;
  logic [VW-1:0]    target;
  logic [6:0]       high;
  logic             has;
  logic             ano;

  cmd_t             pend;
  logic             pend_valid;
  logic [CNT_W-1:0] emit_cnt;
  cmd_t             out_cmd;
  logic             out_valid;
  logic             out_last;

  logic             gen;
  cmd_t             gcmd;
  logic             keep;
  logic             push;
  logic             slot_free;
  logic             go;
  logic             mono_any;
  logic [VW-1:0]    mono_i;
  logic             mask_bit;
  logic [6:0]       pitch_rd;
  logic [31:0]      age_rd;
  logic             apply;

  assign pitch_rd = vpitch[idx];
  assign age_rd   = vage[idx];
  assign mask_bit = (7'(vi) < 7'd16) && it.released_mask[4'(vi)];

  // first live voice other than the new one
  always_comb begin
    mono_any = 1'b0;
    mono_i   = '0;
    for (int k = VOICES - 1; k >= 0; k--) begin
      if (live[k] && (VW'(k) != n)) begin
        mono_any = 1'b1;
        mono_i   = VW'(k);
      end
    end
  end

  always_comb begin
    gen  = 1'b0;
    gcmd = '0;
    case (state)
      S_P_LFO: begin
        gen         = 1'b1;
        gcmd.action = ACT_LFO_RETRIG;
        gcmd.voice  = 4'(n);
      end
      S_P_START: begin
        gen           = 1'b1;
        gcmd.action   = ACT_START;
        gcmd.voice    = 4'(n);
        gcmd.pitch    = it.pitch;
        gcmd.velocity = it.velocity;
        gcmd.channel  = it.channel;
      end
      S_P_OSC: begin
        gen         = osc_sync;
        gcmd.action = ACT_OSC_RESET;
        gcmd.voice  = 4'(n);
      end
      S_P_GLIDE: begin
        gen         = last_valid && porta_en && (porta_time != 7'd0);
        gcmd.action = ACT_GLIDE_FROM;
        gcmd.voice  = 4'(n);
        gcmd.src    = 4'(last_active);
      end
      S_P_MONO: begin
        gen         = mono_mode && mono_any;
        gcmd.action = held[mono_i] ? ACT_TAKE_STATE : ACT_TAKE_SIG;
        gcmd.voice  = 4'(n);
        gcmd.src    = 4'(mono_i);
      end
      S_R_XFER: begin
        gen         = has && live[n];
        gcmd.action = ACT_TAKE_STATE;
        gcmd.voice  = 4'(target);
        gcmd.src    = 4'(n);
      end
      S_R_SUS: begin
        gen         = !sustain_on && live[n];
        gcmd.action = ACT_KEY_REL;
        gcmd.voice  = 4'(n);
      end
      S_SUS: begin
        gen         = sust[vi] && !held[vi];
        gcmd.action = ACT_KEY_REL;
        gcmd.voice  = 4'(vi);
      end
      S_PANIC: begin
        gen         = 1'b1;
        gcmd.action = ACT_OSC_RESET;
        gcmd.voice  = 4'(vi);
      end
      S_TICK: begin
        gen         = live[vi] && !held[vi] && !sust[vi] && mask_bit;
        gcmd.action = ACT_FREED;
        gcmd.voice  = 4'(vi);
      end
      default: begin
        gen = 1'b0;
      end
    endcase
  end

  // commands beyond the cap are dropped, the newest stays held back for last
  assign keep      = gen && (emit_cnt < CNT_W'(CMD_MAX));
  assign push      = pend_valid && (keep || (state == S_DONE));
  assign slot_free = !out_valid || out_ch.ready;
  assign go        = !push || slot_free;
  assign pop       = (state == S_IDLE) && q_valid;
  assign apply     = (state == S_P_APPLY);

  always_ff @(posedge clk) begin
    if (apply) begin
      vpitch[n] <= it.pitch;
      vage[n]   <= note_counter + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      it <= q_item;
    end
    if (push && go) begin
      out_cmd  <= pend;
      out_last <= (state == S_DONE);
    end
    if (keep && go) begin
      pend <= gcmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      held         <= '0;
      sust         <= '0;
      live         <= '0;
      note_counter <= '0;
      next_voice   <= '0;
      last_active  <= '0;
      last_valid   <= 1'b0;
      sustain_on   <= 1'b0;
      porta_en     <= 1'b0;
      porta_time   <= '0;
      pend_valid   <= 1'b0;
      emit_cnt     <= '0;
      out_valid    <= 1'b0;
      idx          <= '0;
      vi           <= '0;
      cnt          <= '0;
      n            <= '0;
      best         <= '0;
      best_age     <= '0;
      target       <= '0;
      high         <= '0;
      has          <= 1'b0;
      ano          <= 1'b0;
    end else begin
      if (push && go) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (keep && go) begin
        pend_valid <= 1'b1;
        emit_cnt   <= emit_cnt + CNT_W'(1);
      end
      if (go) begin
        case (state)
          S_IDLE: begin
            if (q_valid) begin
              case (q_item.op)
                OP_PRESS: begin
                  idx   <= next_voice;
                  cnt   <= '0;
                  state <= S_P_FIND;
                end
                OP_RELEASE: begin
                  idx   <= '0;
                  ano   <= 1'b0;
                  state <= S_R_FIND;
                end
                OP_SUSTAIN: begin
                  sustain_on <= (q_item.ctrl_value >= CTRL_ON_MIN);
                  vi         <= '0;
                  state      <= (q_item.ctrl_value >= CTRL_ON_MIN) ? S_DONE : S_SUS;
                end
                OP_PORTA_EN: begin
                  porta_en <= (q_item.ctrl_value >= CTRL_ON_MIN);
                  state    <= S_DONE;
                end
                OP_PORTA_TIME: begin
                  porta_time <= q_item.ctrl_value;
                  state      <= S_DONE;
                end
                OP_ALL_OFF: begin
                  vi    <= '0;
                  ano   <= 1'b1;
                  state <= S_ANO;
                end
                OP_PANIC: begin
                  held  <= '0;
                  live  <= '0;
                  vi    <= '0;
                  state <= S_PANIC;
                end
                default: begin
                  vi    <= '0;
                  state <= S_TICK;
                end
              endcase
            end
          end
          S_P_FIND: begin
            if (!held[idx]) begin
              n     <= idx;
              state <= S_P_APPLY;
            end else if (cnt == LAST_V) begin
              idx   <= '0;
              state <= S_P_STEAL;
            end else begin
              idx <= (idx == LAST_V) ? '0 : idx + VW'(1);
              cnt <= cnt + VW'(1);
            end
          end
          S_P_STEAL: begin
            if ((idx == '0) || (age_rd < best_age)) begin
              best     <= idx;
              best_age <= age_rd;
            end
            if (idx == LAST_V) begin
              n     <= (age_rd < best_age) ? idx : best;
              state <= S_P_APPLY;
            end else begin
              idx <= idx + VW'(1);
            end
          end
          S_P_APPLY: begin
            next_voice   <= (n == LAST_V) ? '0 : n + VW'(1);
            note_counter <= note_counter + 32'd1;
            held[n]      <= 1'b1;
            live[n]      <= 1'b1;
            sust[n]      <= sustain_on;
            state        <= S_P_LFO;
          end
          S_P_LFO:   state <= S_P_START;
          S_P_START: state <= S_P_OSC;
          S_P_OSC:   state <= S_P_GLIDE;
          S_P_GLIDE: state <= S_P_MONO;
          S_P_MONO: begin
            if (gen) begin
              live[mono_i] <= 1'b0;
            end
            last_active <= n;
            last_valid  <= 1'b1;
            state       <= S_DONE;
          end
          S_R_FIND: begin
            if (held[idx] && (pitch_rd == it.pitch)) begin
              n         <= idx;
              held[idx] <= 1'b0;
              idx       <= '0;
              has       <= 1'b0;
              state     <= mono_mode ? S_R_MONO : S_R_SUS;
            end else if (idx == LAST_V) begin
              state <= S_DONE;
            end else begin
              idx <= idx + VW'(1);
            end
          end
          S_R_MONO: begin
            // highest held note, lowest voice on a tie
            if (held[idx] && (!has || (pitch_rd > high))) begin
              target <= idx;
              high   <= pitch_rd;
              has    <= 1'b1;
            end
            if (idx == LAST_V) begin
              state <= S_R_XFER;
            end else begin
              idx <= idx + VW'(1);
            end
          end
          S_R_XFER: begin
            if (gen) begin
              live[n]      <= 1'b0;
              live[target] <= 1'b1;
            end
            state <= S_R_SUS;
          end
          S_R_SUS: begin
            if (sustain_on) begin
              sust[n] <= 1'b1;
            end
            if (ano && (vi != LAST_V)) begin
              vi    <= vi + VW'(1);
              state <= S_ANO;
            end else begin
              state <= S_DONE;
            end
          end
          S_ANO: begin
            if (held[vi]) begin
              n        <= vi;
              held[vi] <= 1'b0;
              idx      <= '0;
              has      <= 1'b0;
              state    <= mono_mode ? S_R_MONO : S_R_SUS;
            end else if (vi == LAST_V) begin
              state <= S_DONE;
            end else begin
              vi <= vi + VW'(1);
            end
          end
          S_SUS: begin
            if (gen) begin
              sust[vi] <= 1'b0;
            end
            if (vi == LAST_V) begin
              state <= S_DONE;
            end else begin
              vi <= vi + VW'(1);
            end
          end
          S_PANIC: begin
            if (vi == LAST_V) begin
              state <= S_DONE;
            end else begin
              vi <= vi + VW'(1);
            end
          end
          S_TICK: begin
            if (gen) begin
              live[vi] <= 1'b0;
            end
            if (vi == LAST_V) begin
              state <= S_DONE;
            end else begin
              vi <= vi + VW'(1);
            end
          end
          S_DONE: begin
            pend_valid <= 1'b0;
            emit_cnt   <= '0;
            state      <= S_IDLE;
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.action        = out_cmd.action;
  assign out_ch.voice_index   = out_cmd.voice;
  assign out_ch.source_voice  = out_cmd.src;
  assign out_ch.note_pitch    = out_cmd.pitch;
  assign out_ch.note_velocity = out_cmd.velocity;
  assign out_ch.note_channel  = out_cmd.channel;
  assign out_ch.last          = out_last;

  assign status.busy       = (state != S_IDLE);
  assign status.pend_valid = pend_valid;
  assign status.emit_cnt   = emit_cnt;
endmodule

// ----- tb/poly_voice_allocator_tb.sv -----
`timescale 1ns / 100ps

module poly_voice_allocator_tb;
  import pva_pkg::*;

  localparam int NV = 16;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [6:0]  pitch;
    logic [6:0]  velocity;
    logic [6:0]  ctrl_value;
    logic [15:0] released_mask;
  } note_event_t;

  typedef struct packed {
    cmd_t cmd;
    logic last;
  } voice_cmd_t;

  class voice_scoreboard;
    bit held[NV], sustained[NV], live[NV];
    int unsigned vpitch[NV], vvel[NV], vch[NV], vage[NV];
    int unsigned note_count, next_voice, last_voice;
    bit last_ok, sustain_on, porta_on;
    int unsigned porta_len;
    bit mono, osc_sync;
    voice_cmd_t cmd_q[$];
    int burst;
    int errors;

    function new();
      for (int v = 0; v < NV; v++) begin
        held[v] = 0; sustained[v] = 0; live[v] = 0;
        vpitch[v] = 255; vvel[v] = 0; vch[v] = 0; vage[v] = 0;
      end
      note_count = 0; next_voice = 0; last_voice = 0; last_ok = 0;
      sustain_on = 0; porta_on = 0; porta_len = 0; mono = 0; osc_sync = 0;
      errors = 0;
    endfunction

    function void push_cmd(logic [2:0] act, int unsigned v, int unsigned src,
                           int unsigned p, int unsigned vel, int unsigned ch);
      voice_cmd_t e;
      if (burst >= CMD_MAX) return;
      e.cmd.action = act;
      e.cmd.voice = v[3:0];
      e.cmd.src = src[3:0];
      e.cmd.pitch = p[6:0];
      e.cmd.velocity = vel[6:0];
      e.cmd.channel = ch[3:0];
      e.last = 0;
      cmd_q.push_back(e);
      burst++;
    endfunction

    function void lift_key(int unsigned p);
      int n;
      int high;
      int unsigned target;
      n = -1;
      high = -1;
      target = 0;
      for (int i = 0; i < NV; i++)
        if (vpitch[i] == p && held[i]) begin
          held[i] = 0;
          n = i;
          break;
        end
      if (n < 0) return;
      if (mono) begin
        for (int i = 0; i < NV; i++)
          if (held[i] && int'(vpitch[i]) > high) begin
            target = i;
            high = vpitch[i];
          end
        if (high != -1 && live[n]) begin
          live[n] = 0;
          live[target] = 1;
          push_cmd(ACT_TAKE_STATE, target, n, 0, 0, 0);
        end
      end
      if (sustain_on) sustained[n] = 1;
      else if (live[n]) push_cmd(ACT_KEY_REL, n, 0, 0, 0, 0);
    endfunction

    function void strike_key(int unsigned ch, int unsigned p, int unsigned vel);
      int unsigned n, c;
      n = next_voice % NV;
      for (int i = 0; i < NV; i++) begin
        if (!held[n]) break;
        n = (n + 1) % NV;
      end
      // every voice held: steal the oldest
      if (held[n]) begin
        c = 0;
        for (int i = 1; i < NV; i++)
          if (vage[i] < vage[c]) c = i;
        n = c;
      end
      next_voice = (n + 1) % NV;
      vch[n] = ch; vpitch[n] = p; vvel[n] = vel;
      sustained[n] = sustain_on;
      held[n] = 1;
      live[n] = 1;
      note_count++;
      vage[n] = note_count;
      push_cmd(ACT_LFO_RETRIG, n, 0, 0, 0, 0);
      push_cmd(ACT_START, n, 0, p, vel, ch);
      if (osc_sync) push_cmd(ACT_OSC_RESET, n, 0, 0, 0, 0);
      if (last_ok && porta_on && porta_len > 0) push_cmd(ACT_GLIDE_FROM, n, last_voice, 0, 0, 0);
      if (mono) begin
        for (int i = 0; i < NV; i++) begin
          if (i == n || !live[i]) continue;
          live[i] = 0;
          push_cmd(held[i] ? ACT_TAKE_STATE : ACT_TAKE_SIG, n, i, 0, 0, 0);
          break;
        end
      end
      live[n] = 1;
      last_voice = n;
      last_ok = 1;
    endfunction

    // works out the commands that one accepted request causes
    function void note_request(note_event_t r);
      int first;
      first = cmd_q.size();
      burst = 0;
      case (r.kind)
        KIND_NOTE_ON: begin
          if (r.velocity == 0) lift_key(r.pitch);
          else strike_key(r.channel, r.pitch, r.velocity);
        end
        KIND_NOTE_OFF: lift_key(r.pitch);
        KIND_SUSTAIN: begin
          sustain_on = r.ctrl_value > 63;
          if (!sustain_on)
            for (int v = 0; v < NV; v++)
              if (sustained[v] && !held[v]) begin
                push_cmd(ACT_KEY_REL, v, 0, 0, 0, 0);
                sustained[v] = 0;
              end
        end
        KIND_PORTA_EN: porta_on = r.ctrl_value >= CTRL_ON_MIN;
        KIND_PORTA_TIME: porta_len = r.ctrl_value;
        KIND_ALL_OFF: begin
          for (int v = 0; v < NV; v++)
            if (held[v]) lift_key(vpitch[v]);
        end
        KIND_PANIC: begin
          for (int v = 0; v < NV; v++) begin
            vpitch[v] = 255; held[v] = 0; live[v] = 0;
            push_cmd(ACT_OSC_RESET, v, 0, 0, 0, 0);
          end
        end
        default: begin
          for (int v = 0; v < NV; v++)
            if (live[v] && !held[v] && !sustained[v] && r.released_mask[v]) begin
              live[v] = 0;
              vpitch[v] = 255;
              push_cmd(ACT_FREED, v, 0, 0, 0, 0);
            end
        end
      endcase
      if (cmd_q.size() > first) cmd_q[cmd_q.size() - 1].last = 1;
    endfunction

    function void check_command(voice_cmd_t got);
      voice_cmd_t e;
      if (cmd_q.size() == 0) begin
        $error("unexpected command: action %0d voice %0d", got.cmd.action, got.cmd.voice);
        errors++;
        return;
      end
      e = cmd_q.pop_front();
      if (got.cmd.action !== e.cmd.action) begin
        $error("action: expected %0d, got %0d", e.cmd.action, got.cmd.action); errors++;
      end
      if (got.cmd.voice !== e.cmd.voice) begin
        $error("voice_index: expected %0d, got %0d", e.cmd.voice, got.cmd.voice); errors++;
      end
      if (got.cmd.src !== e.cmd.src) begin
        $error("source_voice: expected %0d, got %0d", e.cmd.src, got.cmd.src); errors++;
      end
      if (got.cmd.pitch !== e.cmd.pitch) begin
        $error("note_pitch: expected %0d, got %0d", e.cmd.pitch, got.cmd.pitch); errors++;
      end
      if (got.cmd.velocity !== e.cmd.velocity) begin
        $error("note_velocity: expected %0d, got %0d", e.cmd.velocity, got.cmd.velocity);
        errors++;
      end
      if (got.cmd.channel !== e.cmd.channel) begin
        $error("note_channel: expected %0d, got %0d", e.cmd.channel, got.cmd.channel); errors++;
      end
      if (got.last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic cfg_we;
  logic cfg_addr;
  logic cfg_wdata;

  pva_in_if  in_ch();
  pva_out_if out_ch();

  poly_voice_allocator dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  voice_scoreboard board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    voice_cmd_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.cmd.action = out_ch.action;
      got.cmd.voice = out_ch.voice_index;
      got.cmd.src = out_ch.source_voice;
      got.cmd.pitch = out_ch.note_pitch;
      got.cmd.velocity = out_ch.note_velocity;
      got.cmd.channel = out_ch.note_channel;
      got.last = out_ch.last;
      board.check_command(got);
    end
    if (hold_req) begin
      hold_left <= 700;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_request(note_event_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.kind <= r.kind;
    in_ch.channel <= r.channel;
    in_ch.pitch <= r.pitch;
    in_ch.velocity <= r.velocity;
    in_ch.ctrl_value <= r.ctrl_value;
    in_ch.released_mask <= r.released_mask;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic send_event(logic [2:0] k, int ch, int p, int vel, int cv, int mask);
    note_event_t r;
    r.kind = k;
    r.channel = 4'(ch);
    r.pitch = 7'(p);
    r.velocity = 7'(vel);
    r.ctrl_value = 7'(cv);
    r.released_mask = 16'(mask);
    send_request(r);
  endtask

  // stop offering and let every expected command come out
  task automatic wait_idle();
    in_ch.valid <= 0;
    while (board.cmd_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic addr, logic data);
    @(posedge clk);
    cfg_we <= 1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 0;
    if (addr == CFG_MONO_MODE) board.mono = data;
    else board.osc_sync = data;
  endtask

  task automatic send_random(int count);
    int roll;
    int p;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? $urandom_range(127) : 60 + $urandom_range(11);
      if (roll < 40)
        send_event(KIND_NOTE_ON, $urandom_range(15), p,
                   ($urandom_range(9) == 0) ? 0 : $urandom_range(127, 1), 0, 0);
      else if (roll < 65) send_event(KIND_NOTE_OFF, 0, p, 0, 0, 0);
      else if (roll < 72) send_event(KIND_SUSTAIN, 0, 0, 0, $urandom_range(127), 0);
      else if (roll < 77) send_event(KIND_PORTA_EN, 0, 0, 0, $urandom_range(127), 0);
      else if (roll < 82) send_event(KIND_PORTA_TIME, 0, 0, 0, $urandom_range(127), 0);
      else if (roll < 85) send_event(KIND_ALL_OFF, 0, 0, 0, 0, 0);
      else if (roll < 87) send_event(KIND_PANIC, 0, 0, 0, 0, 0);
      else send_event(KIND_TICK, 0, 0, 0, 0,
                      ($urandom_range(3) == 0) ? 16'hffff : $urandom_range(16'hffff));
    end
  endtask

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst <= 1;
    cfg_we <= 0;
    cfg_addr <= 0;
    cfg_wdata <= 0;
    in_ch.valid <= 0;
    in_ch.kind <= KIND_NOTE_ON;
    in_ch.channel <= 0;
    in_ch.pitch <= 0;
    in_ch.velocity <= 0;
    in_ch.ctrl_value <= 0;
    in_ch.released_mask <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_reg(CFG_MONO_MODE, 0);
    write_reg(CFG_OSC_SYNC, 1);
    send_event(KIND_PORTA_EN, 0, 0, 0, 127, 0);
    send_event(KIND_PORTA_TIME, 0, 0, 0, 127, 0);
    send_event(KIND_NOTE_ON, 15, 127, 127, 0, 0);
    send_event(KIND_NOTE_ON, 0, 0, 1, 0, 0);
    send_event(KIND_NOTE_ON, 3, 0, 0, 0, 0);       // zero velocity acts as a release
    send_event(KIND_NOTE_OFF, 0, 99, 0, 0, 0);     // no voice carries this key
    send_event(KIND_SUSTAIN, 0, 0, 0, 64, 0);
    send_event(KIND_NOTE_OFF, 0, 127, 0, 0, 0);
    send_event(KIND_SUSTAIN, 0, 0, 0, 63, 0);
    send_event(KIND_PORTA_EN, 0, 0, 0, 63, 0);
    send_event(KIND_PORTA_TIME, 0, 0, 0, 0, 0);
    // hold more keys than voices so the oldest gets stolen
    for (int i = 0; i < 17; i++) send_event(KIND_NOTE_ON, i % 16, 40 + i, 100, 0, 0);
    send_event(KIND_ALL_OFF, 0, 0, 0, 0, 0);
    send_event(KIND_TICK, 0, 0, 0, 0, 16'hffff);
    send_event(KIND_PANIC, 0, 0, 0, 0, 0);
    send_event(KIND_TICK, 0, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_MONO_MODE, ph[0] ^ ph[1]);
      write_reg(CFG_OSC_SYNC, ph[0]);
      send_idle_pct = (ph == 1) ? 63 : (ph == 3) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 24 : 0;
      if (ph == 0) begin
        @(posedge clk) hold_req <= 1;
        @(posedge clk) hold_req <= 0;
      end
      send_random(23);
      if (ph == 1) begin
        // sender pause until everything expected is out
        in_ch.valid <= 0;
        while (board.cmd_q.size() > 0) @(posedge clk);
      end
      send_random(23);
      wait_idle();
    end

    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
